// File: src/mit_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mit_pkg
// Shared types and constants of the 4x4 matrix inverse transpose core.
// ----------------------------------------------------------------------------
package mit_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int WIDE       = 64;

  localparam logic signed [WIDE-1:0] SAT_MAX = {1'b0, {(WIDE-1){1'b1}}};

  typedef struct packed {
    logic [3:0]                   elem_index;
    logic signed [ELEM_WIDTH-1:0] elem_value;
    logic                         compute;
  } in_item_t;

  typedef struct packed {
    logic [3:0]                   out_index;
    logic signed [ELEM_WIDTH-1:0] out_value;
    logic                         singular;
    logic                         out_last;
  } out_item_t;

  typedef struct packed {
    logic                   go;
    logic signed [WIDE-1:0] a;
    logic signed [WIDE-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [WIDE-1:0] value;
  } mul_rsp_t;

  typedef struct packed {
    logic                   go;
    logic signed [WIDE-1:0] num;
    logic signed [WIDE-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [ELEM_WIDTH-1:0] value;
  } div_rsp_t;

  function automatic logic [WIDE-1:0] mag(input logic signed [WIDE-1:0] v);
    mag = v[WIDE-1] ? (~v + 1'b1) : v;
  endfunction

endpackage
`default_nettype wire

// File: src/matrix4_inverse_transpose_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4_inverse_transpose_core
// Loads a 4x4 Q16.16 matrix and emits its inverse transpose by cofactors.
// ----------------------------------------------------------------------------
// Loading an element leaves busy low. A transaction with compute set makes
// busy rise: the core walks all sixteen cofactors with one shared multiplier
// (9 products per cofactor), forms the determinant, then emits sixteen
// results, directly when singular or near one, otherwise each one from the
// bit-serial divider. Results appear once each on out_data with out_valid
// high for one cycle and cannot be stalled. Matrix elements and cofactors
// sit in two memories.
module matrix4_inverse_transpose_core (
  input  wire                 logic clk,
  input  wire                 logic rst_n,
  input  wire                 logic start,
  input  mit_pkg::in_item_t   in_data,
  output logic                busy,
  output logic                out_valid,
  output mit_pkg::out_item_t  out_data,
  input  wire                 logic cfg_we,
  input  wire                 logic [15:0] cfg_wdata
);

  localparam int W  = mit_pkg::WIDE;
  localparam int EW = mit_pkg::ELEM_WIDTH;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;
  localparam logic [3:0] S_RDB  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_DRD  = 4'd5;
  localparam logic [3:0] S_DMUL = 4'd6;
  localparam logic [3:0] S_DACC = 4'd7;
  localparam logic [3:0] S_DEC  = 4'd8;
  localparam logic [3:0] S_ORD  = 4'd9;
  localparam logic [3:0] S_OSEL = 4'd10;
  localparam logic [3:0] S_ODIV = 4'd11;

  localparam logic [3:0] LAST_STEP = 4'd8;

  typedef struct packed {
    logic [1:0] an, ak, bn, bk;
    logic       use_t;
    logic [1:0] tsel;
    logic       sub;
    logic       save_t;
    logic [1:0] tdst;
  } step_t;

  // 2x2 terms first, then the outer row of the 3x3 minor
  function automatic step_t step_ops(input logic [3:0] s);
    step_t o;
    o = '0;
    unique case (s)
      4'd0: begin o.an = 2'd1; o.ak = 2'd1; o.bn = 2'd2; o.bk = 2'd2; end
      4'd1: begin o.an = 2'd1; o.ak = 2'd2; o.bn = 2'd2; o.bk = 2'd1; o.sub = 1'b1;
                  o.save_t = 1'b1; o.tdst = 2'd0; end
      4'd2: begin o.an = 2'd1; o.ak = 2'd0; o.bn = 2'd2; o.bk = 2'd2; end
      4'd3: begin o.an = 2'd1; o.ak = 2'd2; o.bn = 2'd2; o.bk = 2'd0; o.sub = 1'b1;
                  o.save_t = 1'b1; o.tdst = 2'd1; end
      4'd4: begin o.an = 2'd1; o.ak = 2'd0; o.bn = 2'd2; o.bk = 2'd1; end
      4'd5: begin o.an = 2'd1; o.ak = 2'd1; o.bn = 2'd2; o.bk = 2'd0; o.sub = 1'b1;
                  o.save_t = 1'b1; o.tdst = 2'd2; end
      4'd6: begin o.an = 2'd0; o.ak = 2'd0; o.use_t = 1'b1; o.tsel = 2'd0; end
      4'd7: begin o.an = 2'd0; o.ak = 2'd1; o.use_t = 1'b1; o.tsel = 2'd1; o.sub = 1'b1; end
      default: begin o.an = 2'd0; o.ak = 2'd2; o.use_t = 1'b1; o.tsel = 2'd2; end
    endcase
    return o;
  endfunction

  // minor position (n, k) of the cofactor at (r, c) to a column-major address
  function automatic logic [3:0] minor_addr(input logic [1:0] r, input logic [1:0] c,
                                            input logic [1:0] n, input logic [1:0] k);
    logic [1:0] rr, cc;
    rr = (n >= r) ? n + 2'd1 : n;
    cc = (k >= c) ? k + 2'd1 : k;
    return {cc, rr};
  endfunction

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s > $signed({1'b0, mit_pkg::SAT_MAX})) begin
      return mit_pkg::SAT_MAX;
    end else if (s < -$signed({1'b0, mit_pkg::SAT_MAX})) begin
      return -mit_pkg::SAT_MAX;
    end
    return s[W-1:0];
  endfunction

  logic [3:0]  state_r, state_nxt;
  logic [3:0]  cof_r;
  logic [3:0]  step_r;
  logic signed [W-1:0] acc_r;
  logic signed [W-1:0] opa_r;
  logic signed [W-1:0] t_r [0:2];
  logic signed [W-1:0] det_r;
  logic        sing_r, one_r;
  logic [15:0] eps_r;
  logic        out_valid_r;
  mit_pkg::out_item_t out_data_r;

  // memories
  logic signed [EW-1:0] mat_mem [0:15];
  logic signed [W-1:0]  cof_mem [0:15];
  logic signed [EW-1:0] mat_rd_r;
  logic signed [W-1:0]  cof_rd_r;
  logic [3:0]           mat_ra;
  logic                 cof_we;
  logic signed [W-1:0]  cof_wd;

  mit_pkg::mul_req_t mul_req;
  mit_pkg::mul_rsp_t mul_rsp;
  mit_pkg::div_req_t div_req;
  mit_pkg::div_rsp_t div_rsp;

  step_t               st;
  logic                accept;
  logic signed [W-1:0] mat_ext;
  logic signed [W-1:0] term;
  logic signed [W-1:0] sum;
  logic signed [W:0]   diff;
  logic [W:0]          diff_mag;
  logic                emit_now;
  logic signed [EW-1:0] emit_val;
  logic signed [EW-1:0] clip_val;

  assign st      = step_ops(step_r);
  assign accept  = start && !busy;
  assign mat_ext = {{(W-EW){mat_rd_r[EW-1]}}, mat_rd_r};
  assign term    = st.sub && (state_r == S_ACC) ? -mul_rsp.value : mul_rsp.value;
  assign sum     = sadd(acc_r, term);

  // distance of the finished determinant sum from one
  assign diff     = {acc_r[W-1], acc_r} - (W+1)'(65'sd1 <<< mit_pkg::FRAC_BITS);
  assign diff_mag = diff[W] ? (~diff + 1'b1) : diff;

  always_comb begin
    unique case (state_r)
      S_RDA:   mat_ra = minor_addr(cof_r[1:0], cof_r[3:2], st.an, st.ak);
      S_RDB:   mat_ra = minor_addr(cof_r[1:0], cof_r[3:2], st.bn, st.bk);
      default: mat_ra = cof_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mat_mem[in_data.elem_index] <= in_data.elem_value;
    end
    mat_rd_r <= mat_mem[mat_ra];
  end

  assign cof_we = (state_r == S_ACC) && mul_rsp.done && (step_r == LAST_STEP);
  // odd row plus column flips the sign of the minor
  assign cof_wd = (cof_r[0] ^ cof_r[2]) ? -sum : sum;

  always_ff @(posedge clk) begin
    if (cof_we) begin
      cof_mem[cof_r] <= cof_wd;
    end
    cof_rd_r <= cof_mem[cof_r];
  end

  always_comb begin
    mul_req.go = (state_r == S_MUL) || (state_r == S_DMUL);
    mul_req.a  = (state_r == S_DMUL) ? mat_ext : opa_r;
    if (state_r == S_DMUL) begin
      mul_req.b = cof_rd_r;
    end else begin
      mul_req.b = st.use_t ? t_r[st.tsel] : mat_ext;
    end
  end

  always_comb begin
    if (cof_rd_r > $signed({{(W-EW+1){1'b0}}, {(EW-1){1'b1}}})) begin
      clip_val = {1'b0, {(EW-1){1'b1}}};
    end else if (cof_rd_r < -$signed({{(W-EW){1'b0}}, 1'b1, {(EW-1){1'b0}}})) begin
      clip_val = {1'b1, {(EW-1){1'b0}}};
    end else begin
      clip_val = cof_rd_r[EW-1:0];
    end
  end

  assign div_req.go  = (state_r == S_OSEL) && !sing_r && !one_r;
  assign div_req.num = cof_rd_r;
  assign div_req.den = det_r;

  always_comb begin
    emit_now = 1'b0;
    emit_val = '0;
    if (state_r == S_OSEL && sing_r) begin
      emit_now = 1'b1;
    end else if (state_r == S_OSEL && one_r) begin
      emit_now = 1'b1;
      emit_val = clip_val;
    end else if (state_r == S_ODIV && div_rsp.done) begin
      emit_now = 1'b1;
      emit_val = div_rsp.value;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && in_data.compute) state_nxt = S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC: begin
        if (mul_rsp.done) begin
          if (step_r == LAST_STEP && cof_r == 4'd15) state_nxt = S_DRD;
          else                                        state_nxt = S_RDA;
        end
      end
      S_DRD:  state_nxt = S_DMUL;
      S_DMUL: state_nxt = S_DACC;
      S_DACC: begin
        if (mul_rsp.done) state_nxt = (cof_r == 4'd3) ? S_DEC : S_DRD;
      end
      S_DEC:  state_nxt = S_ORD;
      S_ORD:  state_nxt = S_OSEL;
      S_OSEL: begin
        if (div_req.go)              state_nxt = S_ODIV;
        else if (cof_r == 4'd15)     state_nxt = S_IDLE;
        else                         state_nxt = S_ORD;
      end
      S_ODIV: begin
        if (div_rsp.done) state_nxt = (cof_r == 4'd15) ? S_IDLE : S_ORD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cof_r       <= '0;
      step_r      <= '0;
      eps_r       <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit_now;
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          cof_r  <= '0;
          step_r <= '0;
          acc_r  <= '0;
        end
        S_RDB: opa_r <= mat_ext;
        S_ACC: begin
          if (mul_rsp.done) begin
            if (step_r == LAST_STEP) begin
              acc_r  <= '0;
              step_r <= '0;
              cof_r  <= cof_r + 4'd1;
            end else begin
              step_r <= step_r + 4'd1;
              if (st.save_t) begin
                t_r[st.tdst] <= sum;
                acc_r        <= '0;
              end else begin
                acc_r <= sum;
              end
            end
          end
        end
        S_DACC: begin
          if (mul_rsp.done) begin
            acc_r <= sum;
            cof_r <= (cof_r == 4'd3) ? 4'd0 : cof_r + 4'd1;
          end
        end
        S_DEC: begin
          det_r  <= acc_r;
          sing_r <= (acc_r == '0) || (mit_pkg::mag(acc_r) < W'(eps_r));
          one_r  <= (acc_r != '0) && !(mit_pkg::mag(acc_r) < W'(eps_r)) &&
                    (diff_mag < (W+1)'(eps_r));
        end
        default: begin
        end
      endcase
      if (emit_now) begin
        cof_r <= cof_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      out_data_r.out_index <= cof_r;
      out_data_r.out_value <= emit_val;
      out_data_r.singular  <= sing_r;
      out_data_r.out_last  <= (cof_r == 4'd15);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mit_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  mit_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a running transaction");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |-> out_data.out_value == '0)
    else $error("singular result carries a nonzero value");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_last |-> out_data.out_index == 4'd15)
    else $error("last flag on wrong index");

  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == S_ACC || state_r == S_DACC))
    else $error("multiplier finished while nobody waits");

endmodule
`default_nettype wire

// File: src/mit_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mit_mul
// Fixed-point multiply (a*b) >> FRAC_BITS on signed 64-bit operands, built
// from four 32x32 partial products, one per cycle, saturated to +-(2^63-1).
// ----------------------------------------------------------------------------
module mit_mul (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  mit_pkg::mul_req_t  req,
  output mit_pkg::mul_rsp_t  rsp
);

  localparam int W = mit_pkg::WIDE;
  localparam int H = W / 2;

  logic [W-1:0]   x_r, y_r;
  logic           neg_r;
  logic [2*W-1:0] acc_r;
  logic [1:0]     cnt_r;
  logic           active_r, fin_r, done_r;
  logic signed [W-1:0] res_r;

  logic [H-1:0]   xp, yp;
  logic [W-1:0]   pp;
  logic [2*W-1:0] pp_sh;
  logic [W-1:0]   rlo;
  logic           ovf;

  // partial product select: cnt bit 0 picks the half of x, bit 1 the half of y
  assign xp    = cnt_r[0] ? x_r[W-1:H] : x_r[H-1:0];
  assign yp    = cnt_r[1] ? y_r[W-1:H] : y_r[H-1:0];
  assign pp    = xp * yp;
  assign pp_sh = {{W{1'b0}}, pp} << (H * (32'(cnt_r[0]) + 32'(cnt_r[1])));

  assign rlo = acc_r[mit_pkg::FRAC_BITS +: W];
  assign ovf = ((acc_r >> (mit_pkg::FRAC_BITS + W)) != '0) || rlo[W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      fin_r    <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      fin_r  <= !req.go && active_r && (cnt_r == 2'd3);
      done_r <= fin_r;
      if (req.go) begin
        x_r      <= mit_pkg::mag(req.a);
        y_r      <= mit_pkg::mag(req.b);
        neg_r    <= req.a[W-1] ^ req.b[W-1];
        acc_r    <= '0;
        cnt_r    <= '0;
        active_r <= 1'b1;
      end else if (active_r) begin
        acc_r <= acc_r + pp_sh;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          active_r <= 1'b0;
        end
      end
      if (fin_r) begin
        if (ovf) begin
          res_r <= neg_r ? -mit_pkg::SAT_MAX : mit_pkg::SAT_MAX;
        end else begin
          res_r <= neg_r ? -$signed(rlo) : $signed(rlo);
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule
`default_nettype wire

// File: src/mit_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mit_div
// Restoring divider, one quotient bit per cycle: (|num| << FRAC_BITS) / |den|
// with the sign of num*den, saturated to the signed element width.
// ----------------------------------------------------------------------------
module mit_div (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  mit_pkg::div_req_t  req,
  output mit_pkg::div_rsp_t  rsp
);

  localparam int W     = mit_pkg::WIDE;
  localparam int EW    = mit_pkg::ELEM_WIDTH;
  localparam int STEPS = W + mit_pkg::FRAC_BITS;
  localparam int CW    = $clog2(STEPS);

  logic [STEPS-1:0] dvd_r;
  logic [W-1:0]     d_r, rem_r;
  logic [EW-1:0]    q_r;
  logic             big_r, neg_r, active_r, fin_r, done_r;
  logic [CW-1:0]    cnt_r;
  logic signed [EW-1:0] res_r;

  logic [W-1:0] rem_sh;
  logic         fits;
  logic         over;

  // remainder stays below |den| < 2^63, so the shift never loses a bit
  assign rem_sh = {rem_r[W-2:0], dvd_r[STEPS-1]};
  assign fits   = rem_sh >= d_r;
  assign over   = big_r | q_r[EW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      fin_r    <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (req.go) begin
        dvd_r    <= {mit_pkg::mag(req.num), {mit_pkg::FRAC_BITS{1'b0}}};
        d_r      <= mit_pkg::mag(req.den);
        neg_r    <= req.num[W-1] ^ req.den[W-1];
        rem_r    <= '0;
        q_r      <= '0;
        big_r    <= 1'b0;
        cnt_r    <= '0;
        active_r <= 1'b1;
      end else if (active_r) begin
        dvd_r <= {dvd_r[STEPS-2:0], 1'b0};
        rem_r <= fits ? (rem_sh - d_r) : rem_sh;
        q_r   <= {q_r[EW-2:0], fits};
        big_r <= big_r | q_r[EW-1];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(STEPS - 1)) begin
          active_r <= 1'b0;
        end
      end
      // fin_r and done_r delay done so the saturated result sees the last quotient bit
      fin_r  <= active_r && !req.go && (cnt_r == CW'(STEPS - 1));
      done_r <= fin_r;
    end
  end

  // saturate the finished quotient to the element range
  always_ff @(posedge clk) begin
    if (neg_r) begin
      res_r <= over ? {1'b1, {(EW-1){1'b0}}} : -$signed(q_r);
    end else begin
      res_r <= over ? {1'b0, {(EW-1){1'b1}}} : $signed(q_r);
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule
`default_nettype wire

// File: tb/matrix4_inverse_transpose_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix4_inverse_transpose_core_tb
// Loads 4x4 Q16.16 matrices into the core and checks every one of the sixteen
// inverse transpose results against an in-bench cofactor/determinant
// predictor, over several tolerance settings, with random start gaps except in the quiet last phase.
// ----------------------------------------------------------------------------
module matrix4_inverse_transpose_core_tb;

  localparam longint POS_LIM = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int     ONE_Q   = 1 << mit_pkg::FRAC_BITS;

  typedef enum int {
    MAT_SMALL, MAT_DIAG, MAT_SINGULAR, MAT_FULL, MAT_IDENT, MAT_MIXED
  } mat_kind_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  mit_pkg::in_item_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  mit_pkg::out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  matrix4_inverse_transpose_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .busy(busy),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial forever #2 clk = ~clk;

  mit_pkg::in_item_t  load_queue[$];
  mit_pkg::out_item_t inverse_queue[$];
  longint    elems[16];
  logic [15:0] tol;
  int        errors = 0;
  bit        quiet = 1'b0;
  int        gap_left = 0;

  // ---------------- predictor ----------------
  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > POS_LIM - b) return POS_LIM;
    if (b < 0 && a < -POS_LIM - b) return -POS_LIM;
    return a + b;
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    p = (128'(abs64(a)) * 128'(abs64(b))) >> mit_pkg::FRAC_BITS;
    if (p > 128'(POS_LIM)) p = 128'(POS_LIM);
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [31:0] clamp_elem(bit neg, logic [127:0] m);
    logic [127:0] lim;
    lim = 128'(1) << (mit_pkg::ELEM_WIDTH - 1);
    if (neg) return (m >= lim) ? 32'(-longint'(lim[63:0])) : 32'(-longint'(m[63:0]));
    if (m > lim - 1) m = lim - 1;
    return m[31:0];
  endfunction

  function automatic longint cofactor_of(int r, int c);
    int rr[3], cc[3], n;
    longint a[3][3], t0, t1, t2, s;
    n = 0;
    for (int k = 0; k < 4; k++) if (k != r) begin rr[n] = k; n++; end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != c) begin cc[n] = k; n++; end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) a[i][j] = elems[cc[j] * 4 + rr[i]];
    t0 = add_sat(qmul(a[1][1], a[2][2]), -qmul(a[1][2], a[2][1]));
    t1 = add_sat(qmul(a[1][0], a[2][2]), -qmul(a[1][2], a[2][0]));
    t2 = add_sat(qmul(a[1][0], a[2][1]), -qmul(a[1][1], a[2][0]));
    s = add_sat(add_sat(qmul(a[0][0], t0), -qmul(a[0][1], t1)), qmul(a[0][2], t2));
    return ((r + c) % 2 == 1) ? -s : s;
  endfunction

  function automatic void predict_inverse(mit_pkg::in_item_t it);
    longint cof[16], det, diff;
    bit sing, one;
    mit_pkg::out_item_t o;
    logic [127:0] q;
    elems[it.elem_index] = longint'(it.elem_value);
    if (!it.compute) return;
    for (int i = 0; i < 16; i++) cof[i] = cofactor_of(i % 4, i / 4);
    det = 0;
    for (int i = 0; i < 4; i++) det = add_sat(det, qmul(elems[i], cof[i]));
    diff = add_sat(det, -longint'(ONE_Q));
    sing = (det == 0) || (abs64(det) < 64'(tol));
    one = !sing && (abs64(diff) < 64'(tol));
    for (int i = 0; i < 16; i++) begin
      o.out_index = 4'(i);
      o.singular = sing;
      o.out_last = (i == 15);
      if (sing) o.out_value = '0;
      else if (one) o.out_value = clamp_elem(cof[i] < 0, 128'(abs64(cof[i])));
      else begin
        q = (128'(abs64(cof[i])) << mit_pkg::FRAC_BITS) / 128'(abs64(det));
        o.out_value = clamp_elem((cof[i] < 0) != (det < 0), q);
      end
      inverse_queue.push_back(o);
    end
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    bit fire;
    fire = start;
    if (rst_n) begin
      if (start && !busy) begin
        predict_inverse(in_data);
        void'(load_queue.pop_front());
        fire = 1'b0;
      end
      if (!fire) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (load_queue.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 3);
          else begin
            fire = 1'b1;
            in_data <= load_queue[0];
          end
        end
      end
      start <= fire;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    mit_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      if (inverse_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: %p", out_data);
      end else begin
        e = inverse_queue.pop_front();
        if (out_data.out_index !== e.out_index || out_data.out_value !== e.out_value ||
            out_data.singular !== e.singular || out_data.out_last !== e.out_last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: idx %0d/%0d val %h/%h sing %b/%b last %b/%b (exp/act)",
                     e.out_index, out_data.out_index, e.out_value, out_data.out_value,
                     e.singular, out_data.singular, e.out_last, out_data.out_last);
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic int small_val();
    return int'($urandom_range(0, 524287)) - 262144;
  endfunction

  function automatic void push_elem(int idx, int val, bit go);
    mit_pkg::in_item_t it;
    it.elem_index = 4'(idx);
    it.elem_value = val;
    it.compute = go;
    load_queue.push_back(it);
  endfunction

  function automatic void push_matrix(mat_kind_t kind);
    int v[16], order[16], j, t;
    for (int i = 0; i < 16; i++) begin
      order[i] = i;
      case (kind)
        MAT_SMALL, MAT_SINGULAR: v[i] = small_val();
        MAT_DIAG: v[i] = (i % 5 == 0) ? ONE_Q * int'($urandom_range(1, 4)) + small_val() / 4
                                      : small_val() / 8;
        MAT_FULL: v[i] = int'($urandom);
        MAT_IDENT: v[i] = (i % 5 == 0) ? ONE_Q : 0;
        default: begin
          case ($urandom_range(0, 7))
            0: v[i] = 32'sh7FFF_FFFF;
            1: v[i] = 32'sh8000_0000;
            2: v[i] = 0;
            default: v[i] = small_val();
          endcase
        end
      endcase
    end
    // repeated column makes the determinant zero
    if (kind == MAT_SINGULAR) for (int i = 0; i < 4; i++) v[12 + i] = v[i];
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < 16; i++) push_elem(order[i], v[order[i]], i == 15);
  endfunction

  task automatic wait_idle();
    while (load_queue.size() > 0 || start || inverse_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_tol(logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tol = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n_items);
    int stop;
    stop = load_queue.size() + n_items;
    while (load_queue.size() < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: push_matrix(mat_kind_t'($urandom_range(0, 5)));
        7, 8: begin
          repeat ($urandom_range(0, 3)) push_elem($urandom_range(0, 15), small_val(), 1'b0);
          push_elem($urandom_range(0, 15), small_val(), 1'b1);
        end
        default: repeat ($urandom_range(1, 6))
          push_elem($urandom_range(0, 15), int'($urandom), $urandom_range(0, 19) == 0);
      endcase
    end
  endtask

  initial begin
    tol = 16'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_tol(16'd1);

    // identity gives det exactly one, then scaled, zero pivot and extremes
    push_matrix(MAT_IDENT);
    push_elem(0, 2 * ONE_Q, 1'b1);
    push_elem(5, 0, 1'b1);
    push_elem(15, 32'sh7FFF_FFFF, 1'b1);
    push_elem(10, 32'sh8000_0000, 1'b1);
    wait_idle();

    write_tol(16'd0);
    random_phase(110);
    wait_idle();
    write_tol(16'hFFFF);
    random_phase(110);
    wait_idle();
    write_tol(16'($urandom_range(2, 65534)));
    random_phase(110);
    wait_idle();
    write_tol(16'd16);
    quiet = 1'b1;
    random_phase(110);
    wait_idle();

    if (errors == 0) $display("matrix4_inverse_transpose_core_tb: done, clean");
    else $display("matrix4_inverse_transpose_core_tb: done, errors");
    $finish;
  end

  initial begin
    #40ms;
    $display("matrix4_inverse_transpose_core_tb: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
src/mit_pkg.sv
src/mit_mul.sv
src/mit_div.sv
src/matrix4_inverse_transpose_core.sv
tb/matrix4_inverse_transpose_core_tb.sv
